// ===== hw/rtl/okle_pkg.sv =====
package okle_pkg;

	// list geometry
	localparam int MAX_ENTRIES_DEF = 16;
	localparam int KEY_W           = 32;

	// request codes
	typedef logic [2:0] req_code_t;
	localparam req_code_t REQ_APPEND = 3'd0;
	localparam req_code_t REQ_DELETE = 3'd1;
	localparam req_code_t REQ_INSERT = 3'd2;
	localparam req_code_t REQ_READ   = 3'd3;
	localparam req_code_t REQ_CLEAR  = 3'd4;

	// status codes
	typedef logic [2:0] status_code_t;
	localparam status_code_t ST_DONE      = 3'd0;
	localparam status_code_t ST_NOT_FOUND = 3'd1;
	localparam status_code_t ST_EMPTY     = 3'd2;
	localparam status_code_t ST_FULL      = 3'd3;
	localparam status_code_t ST_BAD_INDEX = 3'd4;

endpackage

// ===== hw/rtl/okle_store.sv =====
module okle_store
	import okle_pkg::*;
#(
	parameter int DEPTH = MAX_ENTRIES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [KEY_W-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [KEY_W-1:0] rd_data
);

	logic [KEY_W-1:0] mem [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/ordered_key_list_engine.sv =====
// channel | signals                                                        | direction
// in      | in_valid, in_stall, req_type, match_key, new_key, read_index   | request word in
// out     | out_valid, out_stall, status, appended_instead, read_key,
//         | entry_count                                                    | result word out
//
// delete and insert search the store at one entry a cycle and then shift the
// tail at one entry a cycle.
// the single read and single write port of the key store set this pace.
// reset empties the list; the store itself is not cleared and needs no sweep.
// a new request is taken while a finished result waits under out_stall; its
// result is held back until the output register is free.
module ordered_key_list_engine
	import okle_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [2:0]              req_type,
	input  logic signed [KEY_W-1:0] match_key,
	input  logic signed [KEY_W-1:0] new_key,
	input  logic [3:0]              read_index,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [2:0]              status,
	output logic                    appended_instead,
	output logic signed [KEY_W-1:0] read_key,
	output logic [4:0]              entry_count
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT_DN,
		S_SHIFT_UP,
		S_RD_WAIT,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    len_q;
	logic [CW-1:0]    ptr_q;
	logic [CW-1:0]    pos_q;
	req_code_t        req_q;
	logic [KEY_W-1:0] mkey_q;
	logic [KEY_W-1:0] nkey_q;
	status_code_t     status_q;
	logic             app_q;
	logic [KEY_W-1:0] rkey_q;
	logic             pipe_s1;
	logic [AW-1:0]    pipe_idx_s1;

	logic             out_valid_q;
	status_code_t     res_status_q;
	logic             res_app_q;
	logic [KEY_W-1:0] res_rkey_q;
	logic [4:0]       res_count_q;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [KEY_W-1:0] mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [KEY_W-1:0] mem_rdata;

	logic             accept;
	logic             full;
	logic             empty;
	logic [CW+3:0]    idx_ext;
	logic [CW+3:0]    len_ext;
	logic             idx_ok;
	logic [CW+4:0]    cnt_ext;
	logic             hit;
	logic             miss;
	logic             out_free;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign full     = (len_q == CW'(MAX_ENTRIES));
	assign empty    = (len_q == '0);
	assign idx_ext  = (CW+4)'(read_index);
	assign len_ext  = (CW+4)'(len_q);
	assign idx_ok   = (idx_ext < len_ext);
	assign hit      = pipe_s1 && (mem_rdata == mkey_q);
	assign miss     = !pipe_s1 && (ptr_q == len_q);
	assign out_free = !out_valid_q || !out_stall;

	// count as seen after the current step, masked to the port width
	assign cnt_ext  = (CW+5)'(len_q);

	okle_store #(
		.DEPTH (MAX_ENTRIES),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	// store port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_type == REQ_APPEND && !full) begin
						mem_we    = 1'b1;
						mem_waddr = len_q[AW-1:0];
						mem_wdata = match_key;
					end else if (req_type == REQ_INSERT && !full && empty) begin
						mem_we    = 1'b1;
						mem_waddr = '0;
						mem_wdata = new_key;
					end else if (req_type == REQ_READ && idx_ok) begin
						mem_re    = 1'b1;
						mem_raddr = idx_ext[AW-1:0];
					end
				end
			end
			S_SEARCH: begin
				if (ptr_q < len_q) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q[AW-1:0];
				end
			end
			S_SHIFT_DN: begin
				if (ptr_q < len_q) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q[AW-1:0];
				end
				if (pipe_s1) begin
					mem_we    = 1'b1;
					mem_waddr = pipe_idx_s1;
					mem_wdata = mem_rdata;
				end
			end
			S_SHIFT_UP: begin
				if (ptr_q > pos_q) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(ptr_q - CW'(1));
				end
				if (pipe_s1) begin
					mem_we    = 1'b1;
					mem_waddr = pipe_idx_s1;
					mem_wdata = mem_rdata;
				end else if (ptr_q == pos_q) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q[AW-1:0];
					mem_wdata = nkey_q;
				end
			end
			default: begin
			end
		endcase
	end

	// request sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			len_q        <= '0;
			ptr_q        <= '0;
			pos_q        <= '0;
			req_q        <= REQ_APPEND;
			mkey_q       <= '0;
			nkey_q       <= '0;
			status_q     <= ST_DONE;
			app_q        <= 1'b0;
			rkey_q       <= '0;
			pipe_s1      <= 1'b0;
			pipe_idx_s1  <= '0;
			out_valid_q  <= 1'b0;
			res_status_q <= ST_DONE;
			res_app_q    <= 1'b0;
			res_rkey_q   <= '0;
			res_count_q  <= '0;
		end else begin
			// output word leaves
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q    <= req_type;
						mkey_q   <= match_key;
						nkey_q   <= new_key;
						status_q <= ST_DONE;
						app_q    <= 1'b0;
						rkey_q   <= '0;
						ptr_q    <= '0;
						pipe_s1  <= 1'b0;
						state_q  <= S_DONE;
						case (req_type)
							REQ_APPEND: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									len_q <= len_q + CW'(1);
								end
							end
							REQ_DELETE: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else begin
									state_q <= S_SEARCH;
								end
							end
							REQ_INSERT: begin
								if (full) begin
									status_q <= ST_FULL;
								end else if (empty) begin
									len_q <= CW'(1);
								end else begin
									state_q <= S_SEARCH;
								end
							end
							REQ_READ: begin
								if (idx_ok) begin
									state_q <= S_RD_WAIT;
								end else begin
									status_q <= ST_BAD_INDEX;
								end
							end
							REQ_CLEAR: begin
								len_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_SEARCH: begin
					// one read issued per cycle, compared in the cycle after
					pipe_s1     <= mem_re;
					pipe_idx_s1 <= ptr_q[AW-1:0];
					if (mem_re) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (hit || miss) begin
						pipe_s1 <= 1'b0;
					end
					if (hit) begin
						pos_q <= CW'(pipe_idx_s1);
						if (req_q == REQ_DELETE) begin
							ptr_q   <= CW'(pipe_idx_s1) + CW'(1);
							state_q <= S_SHIFT_DN;
						end else begin
							ptr_q   <= len_q;
							state_q <= S_SHIFT_UP;
						end
					end else if (miss) begin
						pos_q <= len_q;
						if (req_q == REQ_DELETE) begin
							status_q <= ST_NOT_FOUND;
							state_q  <= S_DONE;
						end else begin
							app_q   <= 1'b1;
							ptr_q   <= len_q;
							state_q <= S_SHIFT_UP;
						end
					end
				end
				S_SHIFT_DN: begin
					// move entries one step toward the head
					pipe_s1     <= mem_re;
					pipe_idx_s1 <= AW'(ptr_q - CW'(1));
					if (mem_re) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (ptr_q == len_q && !pipe_s1) begin
						len_q   <= len_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_SHIFT_UP: begin
					// move entries one step toward the tail, then place the key
					pipe_s1     <= mem_re;
					pipe_idx_s1 <= ptr_q[AW-1:0];
					if (mem_re) begin
						ptr_q <= ptr_q - CW'(1);
					end
					if (ptr_q == pos_q && !pipe_s1) begin
						len_q   <= len_q + CW'(1);
						state_q <= S_DONE;
					end
				end
				S_RD_WAIT: begin
					rkey_q  <= mem_rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						res_status_q <= status_q;
						res_app_q    <= app_q;
						res_rkey_q   <= rkey_q;
						res_count_q  <= cnt_ext[4:0];
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = res_status_q;
	assign appended_instead = res_app_q;
	assign read_key         = res_rkey_q;
	assign entry_count      = res_count_q;

	// count never passes capacity
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CW'(MAX_ENTRIES))
		else $error("list length beyond capacity");

	// a new output word only comes from the completion state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("output word loaded outside completion");

	// store writes stay inside the array
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW'(mem_waddr) < CW'(MAX_ENTRIES)))
		else $error("store write out of range");

	// the read pipe is only live while walking the store
	a_pipe_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_s1 |-> (state_q == S_SEARCH || state_q == S_SHIFT_DN ||
			state_q == S_SHIFT_UP))
		else $error("read pipe live outside a walk");

	// a shift never reads and writes the same entry in one cycle
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("store read and write collide");

endmodule

// ===== bench/testbench.sv =====
module testbench;
	import okle_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_ITEMS = 2000;
	localparam int CALM_ITEMS   = 300;
	localparam int SETTLE       = 48;
	localparam int CYCLE_LIMIT  = 600000;

	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh80000000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fffffff;

	typedef struct {
		status_code_t            status;
		logic                    appended;
		logic signed [KEY_W-1:0] read_key;
		logic [4:0]              count;
	} list_result_t;

	// mirror of the key list and the results it should produce
	class list_scoreboard;
		logic signed [KEY_W-1:0] keys[MAX_ENTRIES_DEF];
		int                      len;
		list_result_t            expected_q[$];
		int                      errors;
		int                      checked;
		int                      full_hits;
		int                      appended_hits;

		function new();
			foreach (keys[i]) keys[i] = '0;
			len = 0;
			errors = 0;
			checked = 0;
			full_hits = 0;
			appended_hits = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// first position holding key, or len when absent
		function int find_key(logic signed [KEY_W-1:0] key);
			for (int i = 0; i < len; i++) begin
				if (keys[i] == key) return i;
			end
			return len;
		endfunction

		// open a slot at pos by moving the tail one step back
		function void place_key(int pos, logic signed [KEY_W-1:0] key);
			for (int i = len; i > pos; i--) keys[i] = keys[i-1];
			keys[pos] = key;
			len++;
		endfunction

		function void note_request(req_code_t rq, logic signed [KEY_W-1:0] mk,
				logic signed [KEY_W-1:0] nk, logic [3:0] idx);
			list_result_t r;
			int pos;
			r.status   = ST_DONE;
			r.appended = 1'b0;
			r.read_key = '0;
			case (rq)
				REQ_APPEND: begin
					if (len >= MAX_ENTRIES_DEF) r.status = ST_FULL;
					else place_key(len, mk);
				end
				REQ_DELETE: begin
					if (len == 0) begin
						r.status = ST_EMPTY;
					end else begin
						pos = find_key(mk);
						if (pos >= len) begin
							r.status = ST_NOT_FOUND;
						end else begin
							for (int i = pos; i + 1 < len; i++) keys[i] = keys[i+1];
							len--;
						end
					end
				end
				REQ_INSERT: begin
					if (len >= MAX_ENTRIES_DEF) begin
						r.status = ST_FULL;
					end else if (len == 0) begin
						place_key(0, nk);
					end else begin
						pos = find_key(mk);
						if (pos >= len) r.appended = 1'b1;
						place_key(pos, nk);
					end
				end
				REQ_READ: begin
					if (int'(idx) >= len) r.status = ST_BAD_INDEX;
					else r.read_key = keys[idx];
				end
				REQ_CLEAR: len = 0;
				default: ;
			endcase
			if (r.status == ST_FULL) full_hits++;
			if (r.appended) appended_hits++;
			r.count = 5'(len);
			expected_q.push_back(r);
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(status_code_t st, logic app, logic signed [KEY_W-1:0] rk,
				logic [4:0] cnt);
			list_result_t w;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result word with nothing expected (status %0d)", st));
				return;
			end
			w = expected_q.pop_front();
			checked++;
			if (st !== w.status)
				report_mismatch($sformatf("status got %0d want %0d", st, w.status));
			if (app !== w.appended)
				report_mismatch($sformatf("appended_instead got %0b want %0b", app, w.appended));
			if (rk !== w.read_key)
				report_mismatch($sformatf("read_key got %0d want %0d", rk, w.read_key));
			if (cnt !== w.count)
				report_mismatch($sformatf("entry_count got %0d want %0d", cnt, w.count));
		endtask
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [2:0]              req_type;
	logic signed [KEY_W-1:0] match_key;
	logic signed [KEY_W-1:0] new_key;
	logic [3:0]              read_index;
	logic                    out_valid;
	logic                    out_stall;
	logic [2:0]              status;
	logic                    appended_instead;
	logic signed [KEY_W-1:0] read_key;
	logic [4:0]              entry_count;

	list_scoreboard sb;
	bit             tx_idle_en;
	bit             rx_idle_en;
	int             stall_left;
	int             cycles;
	int             words_sent;

	ordered_key_list_engine dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.req_type         (req_type),
		.match_key        (match_key),
		.new_key          (new_key),
		.read_index       (read_index),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.appended_instead (appended_instead),
		.read_key         (read_key),
		.entry_count      (entry_count)
	);

	// clock
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: random stall bursts, changed on the falling edge
	initial begin
		out_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) stall_left--;
			else if (rx_idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
			out_stall <= (stall_left > 0);
		end
	end

	// result word accepted
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status_code_t'(status), appended_instead, read_key, entry_count);
	end

	// one request word through the valid/stall handshake, with an optional gap
	task send_request(req_code_t rq, logic signed [KEY_W-1:0] mk,
			logic signed [KEY_W-1:0] nk, logic [3:0] idx);
		int gap;
		gap = (tx_idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= rq;
		match_key  <= mk;
		new_key    <= nk;
		read_index <= idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(rq, mk, nk, idx);
		words_sent++;
	endtask

	// mostly keys already in the list, so searches hit
	function logic signed [KEY_W-1:0] pick_key();
		int roll;
		roll = $urandom_range(0, 9);
		if (sb.len > 0 && roll < 6) return sb.keys[$urandom_range(0, sb.len - 1)];
		if (roll < 8) return 32'($urandom());
		case ($urandom_range(0, 3))
			0: return KEY_MIN;
			1: return KEY_MAX;
			2: return '0;
			default: return -32'sd1;
		endcase
	endfunction

	initial begin
		req_code_t rq;
		int        roll;
		bit        growing;
		logic [3:0] idx;

		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_APPEND;
		match_key = '0;
		new_key = '0;
		read_index = '0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		cycles = 0;
		words_sent = 0;
		growing = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty list cases, search hits and misses, unknown codes, full list
		send_request(REQ_READ,   '0,      '0,      4'd0);
		send_request(REQ_DELETE, KEY_MIN, '0,      4'd0);
		send_request(REQ_INSERT, KEY_MAX, KEY_MIN, 4'd0);
		send_request(REQ_APPEND, KEY_MAX, '0,      4'd0);
		send_request(REQ_INSERT, KEY_MAX, '0,      4'd0);
		send_request(REQ_INSERT, 32'sd12345, -32'sd1, 4'd0);
		send_request(REQ_DELETE, 32'sd777, '0,     4'd0);
		send_request(REQ_DELETE, KEY_MAX, '0,      4'd0);
		send_request(REQ_READ,   '0,      '0,      4'd0);
		send_request(REQ_READ,   '0,      '0,      4'd15);
		send_request(req_code_t'(3'd5), KEY_MIN, KEY_MAX, 4'd15);
		send_request(req_code_t'(3'd6), '0, '0, 4'd0);
		send_request(req_code_t'(3'd7), -32'sd1, -32'sd1, 4'd7);
		while (sb.len < MAX_ENTRIES_DEF) send_request(REQ_APPEND, 32'($urandom()), '0, 4'd0);
		send_request(REQ_APPEND, KEY_MIN, '0,      4'd0);
		send_request(REQ_INSERT, KEY_MIN, KEY_MAX, 4'd0);
		send_request(REQ_READ,   '0,      '0,      4'd15);
		send_request(REQ_DELETE, sb.keys[MAX_ENTRIES_DEF-1], '0, 4'd0);
		send_request(REQ_CLEAR,  '0,      '0,      4'd0);

		// random: alternating growth and shrink phases
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 120 == 0) growing = !growing;
			if (n == RANDOM_ITEMS - CALM_ITEMS) begin
				tx_idle_en = 1'b0;
				rx_idle_en = 1'b0;
			end
			// hold off until the engine has drained
			if (n == RANDOM_ITEMS / 2) begin
				@(negedge clk);
				in_valid <= 1'b0;
				while (sb.pending() != 0) @(posedge clk);
			end
			roll = $urandom_range(0, 99);
			if (roll < 3) rq = req_code_t'($urandom_range(5, 7));
			else if (roll < 4) rq = growing ? REQ_READ : REQ_CLEAR;
			else if (roll < 22) rq = REQ_READ;
			else if (roll < (growing ? 82 : 42)) rq = $urandom_range(0, 1) ? REQ_APPEND : REQ_INSERT;
			else rq = REQ_DELETE;
			if (sb.len > 0 && $urandom_range(0, 1) == 1) idx = 4'($urandom_range(0, sb.len - 1));
			else idx = 4'($urandom_range(0, 15));
			send_request(rq, pick_key(), pick_key(), idx);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("%0d request words sent, %0d result words checked", words_sent, sb.checked);
		$display("list refused as full %0d times, insert fell back to tail %0d times",
			sb.full_hits, sb.appended_hits);
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/okle_pkg.sv
hw/rtl/okle_store.sv
hw/rtl/ordered_key_list_engine.sv
bench/testbench.sv
